### rtl/softmax_cross_entropy_loss_assert.svh
// Assertion macros for the softmax cross-entropy loss block.
`ifndef SOFTMAX_CROSS_ENTROPY_LOSS_ASSERT_SVH
`define SOFTMAX_CROSS_ENTROPY_LOSS_ASSERT_SVH

// Same-cycle implication, clocked on clk and disabled in reset.
`define SCE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk and disabled in reset.
`define SCE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/sce_pkg.sv
// ----------------------------------------------------------------------------
// Softmax cross-entropy loss package
// Item types, command and status groups, and constant exp tables.
// ----------------------------------------------------------------------------
package sce_pkg;

  localparam int MAX_CLASSES_DEF = 32;
  localparam int CNT_W = 6;
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  typedef struct packed {
    logic signed [15:0] logit;
    logic               target_hot;
    logic               last_class;
  } sce_in_t;

  typedef struct packed {
    logic [5:0]         class_index;
    logic signed [15:0] gradient;
    logic [15:0]        loss_value;
    logic               no_target;
    logic               last_result;
  } sce_out_t;

  typedef enum logic [1:0] {
    DIV_SEL_U,
    DIV_SEL_T,
    DIV_SEL_P
  } div_sel_t;

  typedef struct packed {
    logic     load;
    logic     run_clr;
    logic     exp_ld;
    logic     mul;
    logic     exp_wr;
    logic     ln_start;
    logic     ln_sq;
    logic     t_acc;
    logic     ln_fin;
    logic     j_clr;
    logic     emit;
    logic     div_start;
    div_sel_t div_sel;
  } sce_cmd_t;

  typedef struct packed {
    logic j_last;
    logic qc_zero;
    logic div_done;
    logic term_last;
  } sce_stat_t;

  typedef logic [32:0] exp_tab_t [256];

  // Divides a series term by 256 times the term number, truncating.
  function automatic longint unsigned term_scale(input longint unsigned x, input int n);
    longint unsigned y;
    y = x >> 8;
    case (n)
      1:       term_scale = y;
      2:       term_scale = y >> 1;
      3:       term_scale = y / 64'd3;
      4:       term_scale = y >> 2;
      5:       term_scale = y / 64'd5;
      6:       term_scale = y / 64'd6;
      7:       term_scale = y / 64'd7;
      8:       term_scale = y >> 3;
      9:       term_scale = y / 64'd9;
      10:      term_scale = y / 64'd10;
      11:      term_scale = y / 64'd11;
      12:      term_scale = y / 64'd12;
      default: term_scale = y;
    endcase
  endfunction

  function automatic logic [32:0] exp_series(input int unsigned r);
    longint sum;
    longint unsigned term;
    sum  = 64'sd4294967296;
    term = 64'd4294967296;
    for (int n = 1; n <= 12; n++) begin
      term = term_scale(term * r, n);
      if (n % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    return sum[32:0];
  endfunction

  function automatic exp_tab_t build_exp_tab();
    exp_tab_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = exp_series(i);
    end
    return t;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();
  localparam logic [31:0] EXP_E1 = 32'(exp_series(256));

endpackage

### rtl/sce_div.sv
// ----------------------------------------------------------------------------
// Restoring divider
// Produces a 32-bit quotient one bit per cycle from a preset remainder.
// ----------------------------------------------------------------------------
module sce_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [32:0] rem_init,
  input  logic [31:0] lo,
  input  logic [32:0] den,
  output logic [31:0] quot,
  output logic        done
);

  logic [32:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [32:0] den_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [33:0] rem2;
  logic        ge;

  always_comb begin
    rem2 = {rem_r, quo_r[31]};
    ge = rem2 >= {1'b0, den_r};
    rem_nxt = ge ? 33'(rem2 - {1'b0, den_r}) : rem2[32:0];
    quo_nxt = {quo_r[30:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd32;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= rem_init;
      quo_r <= lo;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign quot = quo_r;
  assign done = done_r;

endmodule

### rtl/sce_ctrl.sv
// ----------------------------------------------------------------------------
// Softmax cross-entropy loss controller
// Sequences loading, the exp pass, the log series and the output pass.
// ----------------------------------------------------------------------------
module sce_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              last_class,
  input  sce_pkg::sce_stat_t stat,
  output sce_pkg::sce_cmd_t  cmd,
  output logic              busy
);
  import sce_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_EXP_RD, S_EXP_LD, S_EXP_MUL, S_EXP_WR, S_LN_START, S_LN_DIV,
    S_LN_SQ, S_T_START, S_T_DIV, S_T_ACC, S_LN_FIN, S_OUT_RD, S_OUT_START,
    S_OUT_DIV, S_OUT_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  always_comb begin
    cmd = '0;
    cmd.div_sel = DIV_SEL_U;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (last_class) begin
            cmd.run_clr = 1'b1;
            state_nxt = S_EXP_RD;
          end
        end
      end
      S_EXP_RD: state_nxt = S_EXP_LD;
      S_EXP_LD: begin
        cmd.exp_ld = 1'b1;
        state_nxt = S_EXP_MUL;
      end
      S_EXP_MUL: begin
        if (stat.qc_zero) begin
          state_nxt = S_EXP_WR;
        end else begin
          cmd.mul = 1'b1;
        end
      end
      S_EXP_WR: begin
        cmd.exp_wr = 1'b1;
        state_nxt = stat.j_last ? S_LN_START : S_EXP_RD;
      end
      S_LN_START: begin
        cmd.ln_start = 1'b1;
        cmd.div_start = 1'b1;
        cmd.div_sel = DIV_SEL_U;
        state_nxt = S_LN_DIV;
      end
      S_LN_DIV: if (stat.div_done) state_nxt = S_LN_SQ;
      S_LN_SQ: begin
        cmd.ln_sq = 1'b1;
        state_nxt = S_T_START;
      end
      S_T_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel = DIV_SEL_T;
        state_nxt = S_T_DIV;
      end
      S_T_DIV: if (stat.div_done) state_nxt = S_T_ACC;
      S_T_ACC: begin
        cmd.t_acc = 1'b1;
        state_nxt = stat.term_last ? S_LN_FIN : S_T_START;
      end
      S_LN_FIN: begin
        cmd.ln_fin = 1'b1;
        cmd.j_clr = 1'b1;
        state_nxt = S_OUT_RD;
      end
      S_OUT_RD: state_nxt = S_OUT_START;
      S_OUT_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel = DIV_SEL_P;
        state_nxt = S_OUT_DIV;
      end
      S_OUT_DIV: if (stat.div_done) state_nxt = S_OUT_EMIT;
      S_OUT_EMIT: begin
        cmd.emit = 1'b1;
        state_nxt = stat.j_last ? S_IDLE : S_OUT_RD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= state_nxt != S_IDLE;
    end
  end

  assign busy = busy_r;

endmodule

### rtl/sce_dpath.sv
// ----------------------------------------------------------------------------
// Softmax cross-entropy loss datapath
// Logit and exp memories, exp multiplier, log series and output registers.
// ----------------------------------------------------------------------------
module sce_dpath #(
  parameter int MAX_CLASSES = sce_pkg::MAX_CLASSES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sce_pkg::sce_in_t   in_data,
  input  sce_pkg::sce_cmd_t  cmd,
  output sce_pkg::sce_stat_t stat,
  output logic              out_valid,
  output sce_pkg::sce_out_t  out_data
);
  import sce_pkg::*;

  localparam int AW = $clog2(MAX_CLASSES);

  logic signed [15:0] logit_mem [MAX_CLASSES];
  logic [16:0]        exp_mem [MAX_CLASSES];
  logic signed [15:0] logit_rd_r;
  logic [16:0]        exp_rd_r;

  logic [CNT_W-1:0]   cnt_r, j_r, tidx_r;
  logic               found_r;
  logic signed [15:0] max_r, zt_r;
  logic [32:0]        v_r;
  logic [3:0]         qc_r;
  logic               ezero_r;
  logic [23:0]        sum_r;
  logic [2:0]         bb_r;
  logic [31:0]        u2_r, p_r;
  logic [33:0]        acc_r;
  logic [3:0]         tk_r;
  logic [15:0]        loss_r;
  logic               out_valid_r;
  sce_out_t           out_r;

  logic               store_ok;
  logic [AW-1:0]      raddr;
  logic [16:0]        kdiff, ktdiff;
  logic [63:0]        vprod, vrnd, usq, pprod;
  logic [33:0]        vround;
  logic [16:0]        e_val;
  logic [2:0]         bb;
  logic [31:0]        ys;
  logic [32:0]        d_rem, d_den;
  logic [31:0]        d_lo, quot;
  logic               div_done;
  logic [34:0]        lnb;
  logic [41:0]        tot;
  logic [16:0]        g;
  logic [15:0]        gsat;
  logic               is_t;

  assign store_ok = cnt_r < CNT_W'(MAX_CLASSES);
  assign raddr = j_r[AW-1:0];

  always_comb begin
    kdiff = {max_r[15], max_r} - {logit_rd_r[15], logit_rd_r};
    ktdiff = {max_r[15], max_r} - {zt_r[15], zt_r};
    vprod = 64'(v_r[31:0]) * 64'(EXP_E1);
    vrnd = vprod + 64'h8000_0000;
    vround = {1'b0, v_r} + 34'h0_0000_8000;
    e_val = ezero_r ? 17'd0 : vround[32:16];
    bb = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (sum_r[16+i]) bb = 3'(i);
    end
    ys = {sum_r, 8'h00} << (3'd7 - bb);
    usq = 64'(quot) * 64'(quot);
    pprod = 64'(p_r) * 64'(u2_r);
    lnb = 35'(bb_r) * 35'(LN2_Q32);
    tot = 42'(lnb) + 42'({acc_r, 1'b0}) + 42'({ktdiff[15:0], 24'h000000})
        + 42'h800000;
    is_t = found_r && (j_r == tidx_r);
    g = {1'b0, quot[15:0]} - (is_t ? 17'h08000 : 17'h00000);
    gsat = (!g[16] && g[15]) ? 16'h7FFF : g[15:0];
  end

  always_comb begin
    case (cmd.div_sel)
      DIV_SEL_U: begin
        d_rem = {1'b0, ys} - 33'h0_8000_0000;
        d_lo  = 32'h0;
        d_den = {1'b0, ys} + 33'h0_8000_0000;
      end
      DIV_SEL_T: begin
        d_rem = 33'h0;
        d_lo  = p_r;
        d_den = 33'({tk_r, 1'b1});
      end
      DIV_SEL_P: begin
        d_rem = 33'h0;
        d_lo  = {exp_rd_r, 15'h0000} + {9'h000, sum_r[23:1]};
        d_den = 33'(sum_r);
      end
      default: begin
        d_rem = 33'h0;
        d_lo  = 32'h0;
        d_den = 33'h1;
      end
    endcase
  end

  sce_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .rem_init (d_rem),
    .lo       (d_lo),
    .den      (d_den),
    .quot     (quot),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (cmd.load && store_ok) begin
      logit_mem[cnt_r[AW-1:0]] <= in_data.logit;
    end
    if (cmd.exp_wr) begin
      exp_mem[raddr] <= e_val;
    end
    logit_rd_r <= logit_mem[raddr];
    exp_rd_r   <= exp_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      tidx_r      <= '0;
      found_r     <= 1'b0;
      max_r       <= 16'sh8000;
      sum_r       <= '0;
      j_r         <= '0;
      qc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
      if (cmd.load && store_ok) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (in_data.target_hot && !found_r) begin
          found_r <= 1'b1;
          tidx_r  <= cnt_r;
        end
        if (in_data.logit > max_r) begin
          max_r <= in_data.logit;
        end
      end
      if (cmd.run_clr) begin
        sum_r <= '0;
        j_r   <= '0;
      end
      if (cmd.exp_ld) begin
        qc_r <= (|kdiff[15:12]) ? 4'd0 : kdiff[11:8];
      end
      if (cmd.mul) begin
        qc_r <= qc_r - 4'd1;
      end
      if (cmd.exp_wr) begin
        sum_r <= sum_r + 24'(e_val);
        j_r   <= j_r + CNT_W'(1);
      end
      if (cmd.j_clr) begin
        j_r <= '0;
      end
      if (cmd.emit) begin
        j_r <= j_r + CNT_W'(1);
        if (stat.j_last) begin
          cnt_r   <= '0;
          tidx_r  <= '0;
          found_r <= 1'b0;
          max_r   <= 16'sh8000;
          sum_r   <= '0;
          j_r     <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && store_ok && in_data.target_hot && !found_r) begin
      zt_r <= in_data.logit;
    end
    if (cmd.exp_ld) begin
      v_r     <= EXP_TAB[kdiff[7:0]];
      ezero_r <= |kdiff[15:12];
    end
    if (cmd.mul) begin
      v_r <= v_r[32] ? {1'b0, EXP_E1} : {1'b0, vrnd[63:32]};
    end
    if (cmd.ln_start) begin
      bb_r <= bb;
    end
    if (cmd.ln_sq) begin
      u2_r  <= usq[63:32];
      p_r   <= quot;
      acc_r <= '0;
      tk_r  <= '0;
    end
    if (cmd.t_acc) begin
      acc_r <= acc_r + 34'(quot);
      p_r   <= pprod[63:32];
      tk_r  <= tk_r + 4'd1;
    end
    if (cmd.ln_fin) begin
      if (!found_r) begin
        loss_r <= 16'h0000;
      end else if (|tot[41:40]) begin
        loss_r <= 16'hFFFF;
      end else begin
        loss_r <= tot[39:24];
      end
    end
    if (cmd.emit) begin
      out_r.class_index <= j_r;
      out_r.gradient    <= gsat;
      out_r.loss_value  <= stat.j_last ? loss_r : 16'h0000;
      out_r.no_target   <= !found_r;
      out_r.last_result <= stat.j_last;
    end
  end

  assign stat.j_last    = CNT_W'(j_r + CNT_W'(1)) == cnt_r;
  assign stat.qc_zero   = qc_r == 4'd0;
  assign stat.div_done  = div_done;
  assign stat.term_last = tk_r == 4'd9;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### rtl/softmax_cross_entropy_loss.sv
// ----------------------------------------------------------------------------
// Softmax cross-entropy loss
// Loads a vector of Q8.8 logits and emits per-class gradients and the loss.
// ----------------------------------------------------------------------------
// Channel   Ports                      Handshake
// input     in_data                    start high, busy low
// result    out_data                   out_valid strobe, one cycle
//
// Loading takes one logit per cycle while busy is low.
// Closing item: per class an exp step with q multiplies (q up to 15), then a
// divide for the log argument, a ten-term log series with one divide per term
// and a finish; each result needs one divide of the one-bit-per-cycle divider.
// Reset is synchronous on rst_n and clears all control state.
// The receiver cannot stall; results are strobed as they finish.
module softmax_cross_entropy_loss #(
  parameter int MAX_CLASSES = sce_pkg::MAX_CLASSES_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  sce_pkg::sce_in_t in_data,
  output logic            out_valid,
  output sce_pkg::sce_out_t out_data
);
  import sce_pkg::*;

  sce_cmd_t  cmd;
  sce_stat_t stat;

  sce_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .last_class (in_data.last_class),
    .stat       (stat),
    .cmd        (cmd),
    .busy       (busy)
  );

  sce_dpath #(
    .MAX_CLASSES (MAX_CLASSES)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

### rtl/sce_checker.sv
// ----------------------------------------------------------------------------
// Softmax cross-entropy loss checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "softmax_cross_entropy_loss_assert.svh"

module sce_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input sce_pkg::sce_in_t  in_data,
  input logic             out_valid,
  input sce_pkg::sce_out_t out_data
);

  `SCE_ASSERT_IMP(a_more_pending, out_valid && !out_data.last_result, busy, "busy low mid run")
  `SCE_ASSERT_NXT(a_strobe_gap, out_valid, !out_valid, "results back to back")
  `SCE_ASSERT_NXT(a_load_open, start && !busy && !in_data.last_class, !busy, "load stalled")
  `SCE_ASSERT_NXT(a_close_busy, start && !busy && in_data.last_class, busy, "close not taken")

endmodule

bind softmax_cross_entropy_loss sce_checker u_sce_checker (.*);

### dv/tb_softmax_cross_entropy_loss.sv
// ----------------------------------------------------------------------------
// Softmax cross-entropy loss testbench
// Sends logit vectors through the command-style input and checks every
// per-class gradient, loss and flag against a fixed-point predictor.
// ----------------------------------------------------------------------------
module tb_softmax_cross_entropy_loss;
  timeunit 1ns;
  timeprecision 1ps;

  import sce_pkg::*;

  localparam int NCLS = MAX_CLASSES_DEF;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  sce_in_t  in_data = '0;
  logic     out_valid;
  sce_out_t out_data;

  softmax_cross_entropy_loss DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  always #1 clk = ~clk;

  int errors = 0;
  int items_sent = 0;
  int vectors_closed = 0;
  int results_seen = 0;
  bit no_idle = 1'b0;
  sce_out_t expected_grads[$];

  logic signed [15:0] vec_logits[NCLS];
  int unsigned        vec_count = 0;
  int unsigned        vec_target = 0;
  bit                 vec_found = 1'b0;
  logic signed [15:0] vec_max = -16'sd32768;

  function automatic bit [63:0] taylor_exp_neg(int unsigned r);
    longint      acc;
    bit [63:0]   term;
    acc  = 64'sd4294967296;
    term = 64'd4294967296;
    for (int n = 1; n <= 12; n++) begin
      term = (term * r) / (256 * n);
      if (n % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    return acc;
  endfunction

  function automatic bit [31:0] exp_dist_q16(int unsigned k);
    int unsigned q;
    bit [63:0]   v;
    bit [63:0]   e1;
    q = (k >> 8) & 8'hFF;
    if (q >= 16) begin
      return 0;
    end
    v  = taylor_exp_neg(k & 8'hFF);
    e1 = taylor_exp_neg(256);
    for (int i = 0; i < q; i++) begin
      v = (v * e1 + 64'h8000_0000) >> 32;
    end
    return (v + 64'h8000) >> 16;
  endfunction

  function automatic bit [63:0] log_sum_q32(bit [31:0] s);
    int unsigned b;
    bit [63:0]   ys, u, u2, p, acc;
    b = 23;
    acc = 0;
    while (b > 16 && s[b] == 1'b0) begin
      b--;
    end
    ys = 64'(s) << (31 - b);
    u  = ((ys - 64'h8000_0000) << 32) / (ys + 64'h8000_0000);
    u2 = (u * u) >> 32;
    p  = u;
    for (int k = 0; k < 10; k++) begin
      acc = acc + p / (2 * k + 1);
      p = (p * u2) >> 32;
    end
    return 64'(b - 16) * 64'd2977044472 + 2 * acc;
  endfunction

  task automatic predict_item(sce_in_t it);
    bit [31:0] exps[NCLS];
    bit [31:0] esum;
    bit [63:0] tot, loss, p;
    int        g;
    sce_out_t  r;
    if (vec_count < NCLS) begin
      vec_logits[vec_count] = it.logit;
      if (it.target_hot && !vec_found) begin
        vec_found  = 1'b1;
        vec_target = vec_count;
      end
      if (it.logit > vec_max) begin
        vec_max = it.logit;
      end
      vec_count++;
    end
    if (!it.last_class) begin
      return;
    end
    esum = 0;
    loss = 0;
    for (int j = 0; j < vec_count; j++) begin
      exps[j] = exp_dist_q16(32'(int'(vec_max) - int'(vec_logits[j])));
      esum = esum + exps[j];
    end
    if (vec_found) begin
      tot = log_sum_q32(esum) +
            (64'(32'(int'(vec_max) - int'(vec_logits[vec_target]))) << 24);
      loss = (tot + 64'h80_0000) >> 24;
      if (loss > 65535) begin
        loss = 65535;
      end
    end
    for (int j = 0; j < vec_count; j++) begin
      p = (64'(exps[j]) * 32768 + esum / 2) / esum;
      g = int'(p);
      if (vec_found && j == vec_target) begin
        g = g - 32768;
      end
      if (g > 32767) begin
        g = 32767;
      end
      r.class_index = j[5:0];
      r.gradient    = g[15:0];
      r.loss_value  = (j + 1 == vec_count) ? loss[15:0] : 16'd0;
      r.no_target   = !vec_found;
      r.last_result = (j + 1 == vec_count);
      expected_grads.push_back(r);
    end
    vectors_closed++;
    vec_count  = 0;
    vec_target = 0;
    vec_found  = 1'b0;
    vec_max    = -16'sd32768;
  endtask

  task automatic send_item(logic signed [15:0] z, bit hot, bit last);
    sce_in_t it;
    int      gap;
    it.logit = z;
    it.target_hot = hot;
    it.last_class = last;
    @(negedge clk);
    start = 1'b1;
    in_data = it;
    while (busy) @(negedge clk);
    @(posedge clk);
    predict_item(it);
    items_sent++;
    gap = 0;
    if (!no_idle && $urandom_range(0, 1)) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
    end
    if (gap > 0) begin
      @(negedge clk);
      start = 1'b0;
      in_data = sce_in_t'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  always @(posedge clk) begin
    sce_out_t e;
    if (rst_n && out_valid) begin
      results_seen++;
      if (expected_grads.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, actual %p", $time, out_data);
      end else begin
        e = expected_grads.pop_front();
        if (out_data.class_index !== e.class_index ||
            out_data.gradient !== e.gradient ||
            out_data.loss_value !== e.loss_value ||
            out_data.no_target !== e.no_target ||
            out_data.last_result !== e.last_result) begin
          errors++;
          $display("%0t: mismatch, expected %p, actual %p", $time, e, out_data);
        end
      end
    end
  end

  task automatic test_extremes();
    send_item(16'sh7FFF, 1'b0, 1'b0);
    send_item(-16'sh8000, 1'b1, 1'b1);
    send_item(-16'sh8000, 1'b0, 1'b0);
    send_item(16'sh0000, 1'b1, 1'b0);
    send_item(16'sh0100, 1'b1, 1'b0);
    send_item(-16'sh0F00, 1'b0, 1'b1);
  endtask

  task automatic test_single_class();
    send_item(16'sh1234, 1'b1, 1'b1);
    send_item(-16'sh0421, 1'b0, 1'b1);
  endtask

  task automatic test_no_target();
    send_item(16'sh0080, 1'b0, 1'b0);
    send_item(16'sh0000, 1'b0, 1'b0);
    send_item(-16'sh0200, 1'b0, 1'b1);
  endtask

  task automatic test_overflow();
    for (int i = 0; i < NCLS + 3; i++) begin
      send_item(16'($urandom_range(0, 2047)) - 16'sd1024, i == NCLS + 1, i == NCLS + 2);
    end
  endtask

  task automatic test_random();
    int len, tgt, base;
    bit wide;
    while (items_sent < 130) begin
      no_idle = ($urandom_range(0, 4) == 0);
      len  = ($urandom_range(0, 12) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 8);
      wide = ($urandom_range(0, 3) == 0);
      tgt  = $urandom_range(0, 5) == 0 ? -1 : $urandom_range(0, len - 1);
      base = $urandom_range(0, 65535) - 32768;
      for (int i = 0; i < len; i++) begin
        send_item(wide ? 16'($urandom) : 16'(base + $urandom_range(0, 1535) - 768),
                  (i == tgt) || ($urandom_range(0, 9) == 0), i == len - 1);
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_extremes();
    test_single_class();
    test_no_target();
    test_overflow();
    test_random();
    @(negedge clk);
    start = 1'b0;
    while (expected_grads.size() != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
    $display("Sent %0d items closing %0d vectors; checked %0d results.",
             items_sent, vectors_closed, results_seen);
    if (errors == 0) begin
      $display("tb_softmax_cross_entropy_loss: done, clean");
    end else begin
      $display("tb_softmax_cross_entropy_loss: done, errors");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("tb_softmax_cross_entropy_loss: done, errors");
    $finish;
  end

endmodule

### softmax_cross_entropy_loss.f
+incdir+rtl
rtl/sce_pkg.sv
rtl/sce_div.sv
rtl/sce_ctrl.sv
rtl/sce_dpath.sv
rtl/softmax_cross_entropy_loss.sv
rtl/sce_checker.sv
dv/tb_softmax_cross_entropy_loss.sv
